// ===== sv/btr_pkg.sv =====
// Package for the block transfer receiver: shared constants, verdict codes
// and the record type that passes from the front end to the back end.
// No dependencies.
package btr_pkg;

   // Header layout and the acknowledgement for a finished transfer.
   localparam int unsigned HdrBytes = 6;
   localparam logic [15:0] AckComplete = 16'hFFFF;
   localparam logic [15:0] PosMax = 16'hFFFF;

   // Depth of the queue between the front end and the back end.
   localparam int unsigned MidDepth = 2;
   localparam int unsigned MidPtrBits = (MidDepth > 1) ? $clog2(MidDepth) : 1;
   localparam int unsigned MidCntBits = $clog2(MidDepth + 1);

   // Verdict codes as they appear on the result channel.
   localparam logic [2:0] VerdictShort = 3'd0;
   localparam logic [2:0] VerdictError = 3'd1;
   localparam logic [2:0] VerdictComplete = 3'd2;
   localparam logic [2:0] VerdictAccepted = 3'd3;
   localparam logic [2:0] VerdictDuplicate = 3'd4;
   localparam logic [2:0] VerdictAhead = 3'd5;

   // Classification made by the front end at the end of a datagram.
   localparam logic [1:0] KindShort = 2'd0;
   localparam logic [1:0] KindError = 2'd1;
   localparam logic [1:0] KindComplete = 2'd2;
   localparam logic [1:0] KindBlock = 2'd3;

   // One classified byte on its way to the back end.
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic        end_of_datagram;
      logic [1:0]  kind;
      logic [15:0] block_number;
      logic [7:0]  length;
   } item_type;

   // One finished result.
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic        verdict_valid;
      logic [2:0]  verdict;
      logic        ack_valid;
      logic [15:0] ack_value;
      logic [31:0] bytes_accepted;
   } result_type;

endpackage

// ===== sv/btr_front.sv =====
// Front end of the block transfer receiver: parses the header, sums the
// payload and classifies each datagram at its final byte. Uses btr_pkg.
module btr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        rx_byte,
   input  logic              end_of_datagram,
   output btr_pkg::item_type item
);
   import btr_pkg::*;

   logic [15:0] pos_ff, pos_in;
   logic [15:0] blk_ff, blk_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] hsum_ff, hsum_in;
   logic [15:0] run_ff, run_in;
   logic [15:0] run_new;
   logic [15:0] pos_less_hdr;
   logic [15:0] pos_less_last;
   logic        in_payload;
   logic        pv;

   // Header capture, one field byte at each header position except the pad.
   always_comb begin
      blk_in  = blk_ff;
      len_in  = len_ff;
      hsum_in = hsum_ff;
      case (pos_ff)
         16'd0: blk_in[7:0] = rx_byte;
         16'd1: blk_in[15:8] = rx_byte;
         16'd2: len_in = rx_byte;
         16'd3: ;
         16'd4: hsum_in[7:0] = rx_byte;
         16'd5: hsum_in[15:8] = rx_byte;
         default: ;
      endcase
   end

   // Payload bytes within the declared length are passed on and summed.
   assign pos_less_hdr  = pos_ff - 16'(HdrBytes);
   assign pos_less_last = pos_ff - 16'(HdrBytes - 1);
   assign in_payload    = pos_ff >= 16'(HdrBytes);
   assign pv            = in_payload && (pos_less_hdr < {8'd0, len_ff});
   assign run_new       = pv ? run_ff + {8'd0, rx_byte} : run_ff;

   // Position saturates; position and sum restart after the final byte.
   always_comb begin
      if (end_of_datagram) begin
         pos_in = '0;
         run_in = '0;
      end else begin
         pos_in = (pos_ff != PosMax) ? pos_ff + 16'd1 : pos_ff;
         run_in = run_new;
      end
   end

   // Classification of the datagram, meaningful on its final byte only.
   always_comb begin
      item.payload_byte    = pv ? rx_byte : 8'd0;
      item.payload_valid   = pv;
      item.end_of_datagram = end_of_datagram;
      item.block_number    = blk_in;
      item.length          = len_in;
      if (pos_ff < 16'(HdrBytes - 1)) begin
         item.kind = KindShort;
      end else if ((pos_less_last < {8'd0, len_in}) || (run_new != hsum_in)) begin
         item.kind = KindError;
      end else if (len_in == 8'd0) begin
         item.kind = KindComplete;
      end else begin
         item.kind = KindBlock;
      end
   end

   // State update on each accepted transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         blk_ff  <= '0;
         len_ff  <= '0;
         hsum_ff <= '0;
         run_ff  <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         blk_ff  <= blk_in;
         len_ff  <= len_in;
         hsum_ff <= hsum_in;
         run_ff  <= run_in;
      end
   end

endmodule

// ===== sv/btr_queue.sv =====
// Short register queue between the front end and the back end of the
// block transfer receiver. Uses btr_pkg for its depth and record type.
module btr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  btr_pkg::item_type wr_item,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output btr_pkg::item_type rd_item
);
   import btr_pkg::*;

   item_type              mem_ff [MidDepth];
   logic [MidPtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [MidPtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [MidCntBits-1:0] cnt_ff, cnt_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = cnt_ff == MidCntBits'(MidDepth);
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_item = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates, with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == MidPtrBits'(MidDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == MidPtrBits'(MidDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// ===== sv/btr_back.sv =====
// Back end of the block transfer receiver: compares the block number with
// the expected one, keeps the counters and holds the result register.
// Uses btr_pkg.
module btr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_avail,
   input  btr_pkg::item_type   item,
   output logic                item_take,
   input  logic                res_pop,
   output logic                res_valid,
   output btr_pkg::result_type res
);
   import btr_pkg::*;

   logic [15:0] expect_ff, expect_in;
   logic [31:0] total_ff, total_in;
   logic        valid_ff, valid_in;
   result_type  res_ff, res_in;
   logic        slot_free;

   // The result register is free when empty or being taken this cycle.
   assign slot_free = !valid_ff || res_pop;
   assign item_take = item_avail && slot_free;
   assign res_valid = valid_ff;
   assign res       = res_ff;

   // Verdict and counter updates for the item at the head of the queue.
   always_comb begin
      expect_in = expect_ff;
      total_in  = total_ff;
      res_in.payload_byte  = item.payload_byte;
      res_in.payload_valid = item.payload_valid;
      res_in.verdict_valid = item.end_of_datagram;
      res_in.verdict       = VerdictShort;
      res_in.ack_valid     = 1'b0;
      res_in.ack_value     = '0;
      if (item.end_of_datagram) begin
         case (item.kind)
            KindShort: res_in.verdict = VerdictShort;
            KindError: res_in.verdict = VerdictError;
            KindComplete: begin
               res_in.verdict   = VerdictComplete;
               res_in.ack_valid = 1'b1;
               res_in.ack_value = AckComplete;
            end
            KindBlock: begin
               if (item.block_number == expect_ff) begin
                  res_in.verdict   = VerdictAccepted;
                  res_in.ack_valid = 1'b1;
                  res_in.ack_value = expect_ff;
                  expect_in        = expect_ff + 16'd1;
                  total_in         = total_ff + {24'd0, item.length};
               end else if (item.block_number < expect_ff) begin
                  res_in.verdict   = VerdictDuplicate;
                  res_in.ack_valid = 1'b1;
                  res_in.ack_value = item.block_number;
               end else begin
                  res_in.verdict = VerdictAhead;
               end
            end
            default: res_in.verdict = VerdictShort;
         endcase
      end
      res_in.bytes_accepted = total_in;
   end

   // Result register occupancy.
   always_comb begin
      valid_in = valid_ff;
      if (item_take) begin
         valid_in = 1'b1;
      end else if (res_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff <= '0;
         total_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (item_take) begin
            expect_ff <= expect_in;
            total_ff  <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         res_ff <= res_in;
      end
   end

endmodule

// ===== sv/block_transfer_receiver_core.sv =====
// Block transfer receiver: parses datagram bytes and gives one result per
// byte, including the verdict and acknowledgement on the final byte.
// Instantiates btr_front, btr_queue and btr_back; uses btr_pkg.
//
// Input channel: a byte transfer is taken when req_push is high and
// req_full is low. req_end_of_datagram marks the final byte of a datagram.
// Result channel: while rsp_empty is low, the oldest result is on the rsp_
// ports; it is taken when rsp_pop is high. Every byte yields one result.
// A taken byte passes through the middle queue and the result register
// before its result shows, when nothing waits ahead of it. Throughput:
// one byte per cycle while req_full is low, set by the combinational
// header parse and sum in the front end, block compare in the back end.
// Reset clears the parse position, header fields, sums, the expected block
// number, the byte total, the middle queue and the result register.
// When the receiver stops popping, up to three results collect (two in the
// middle queue, one in the result register) and then req_full rises.
module block_transfer_receiver_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_end_of_datagram,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_payload_valid,
   output logic        rsp_verdict_valid,
   output logic [2:0]  rsp_verdict,
   output logic        rsp_ack_valid,
   output logic [15:0] rsp_ack_value,
   output logic [31:0] rsp_bytes_accepted
);
   import btr_pkg::*;

   item_type   front_item;
   item_type   head_item;
   result_type res;
   logic       mid_full;
   logic       mid_empty;
   logic       mid_take;
   logic       res_valid;
   logic       in_accept;

   assign in_accept = req_push && !mid_full;
   assign req_full  = mid_full;

   // Header parse and classification.
   btr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (in_accept),
      .rx_byte         (req_rx_byte),
      .end_of_datagram (req_end_of_datagram),
      .item            (front_item)
   );

   // Decoupling queue.
   btr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (in_accept),
      .wr_item (front_item),
      .full    (mid_full),
      .pop     (mid_take),
      .empty   (mid_empty),
      .rd_item (head_item)
   );

   // Verdict, counters and result register.
   btr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_avail (!mid_empty),
      .item       (head_item),
      .item_take  (mid_take),
      .res_pop    (rsp_pop && res_valid),
      .res_valid  (res_valid),
      .res        (res)
   );

   assign rsp_empty          = !res_valid;
   assign rsp_payload_byte   = res.payload_byte;
   assign rsp_payload_valid  = res.payload_valid;
   assign rsp_verdict_valid  = res.verdict_valid;
   assign rsp_verdict        = res.verdict;
   assign rsp_ack_valid      = res.ack_valid;
   assign rsp_ack_value      = res.ack_value;
   assign rsp_bytes_accepted = res.bytes_accepted;

`ifndef SYNTH
   // An acknowledgement only goes with a complete, accepted or duplicate verdict.
   a_ack_verdict: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_ack_valid) |->
         (rsp_verdict_valid && (rsp_verdict == VerdictComplete ||
          rsp_verdict == VerdictAccepted || rsp_verdict == VerdictDuplicate)))
      else $error("acknowledgement without a matching verdict");

   // Results that carry no verdict report neither a verdict code nor an ack.
   a_no_verdict: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_verdict_valid) |->
         (rsp_verdict == VerdictShort && !rsp_ack_valid && rsp_ack_value == 16'd0))
      else $error("verdict fields set on a byte that ends no datagram");

   // The byte total only moves on an accepted block.
   a_total_moves: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop) ##1 (!rsp_empty &&
         rsp_bytes_accepted != $past(rsp_bytes_accepted)) |->
         (rsp_verdict == VerdictAccepted))
      else $error("byte total changed without an accepted block");
`endif

endmodule

// ===== sim/btr_checker.sv =====
`timescale 1ns / 100ps
// Checker for block_transfer_receiver_core: watches both channels, predicts one
// result per byte transfer and compares it field by field. Uses btr_pkg.
module btr_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_end_of_datagram,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [7:0]  rsp_payload_byte,
   input  logic        rsp_payload_valid,
   input  logic        rsp_verdict_valid,
   input  logic [2:0]  rsp_verdict,
   input  logic        rsp_ack_valid,
   input  logic [15:0] rsp_ack_value,
   input  logic [31:0] rsp_bytes_accepted,
   output int unsigned pending,
   output int unsigned failures
);
   import btr_pkg::*;

   // Byte offsets of the header fields within a datagram.
   localparam logic [15:0] OffBlockLow = 16'd0;
   localparam logic [15:0] OffBlockHigh = 16'd1;
   localparam logic [15:0] OffLength = 16'd2;
   localparam logic [15:0] OffPad = 16'd3;
   localparam logic [15:0] OffSumLow = 16'd4;
   localparam logic [15:0] OffSumHigh = 16'd5;

   // Receiver state as the predictor sees it.
   logic [15:0] position;
   logic [15:0] hdr_block;
   logic [7:0]  hdr_length;
   logic [15:0] hdr_sum;
   logic [15:0] payload_sum;
   logic [15:0] next_block;
   logic [31:0] total_accepted;

   result_type results_due[$];
   result_type want;
   int unsigned mismatches = 0;

   // Works out the result of one byte and advances the parse state.
   task automatic classify_byte(input logic [7:0] value, input logic last,
                                output result_type r);
      logic [31:0] span;
      r = '0;
      case (position)
         OffBlockLow: hdr_block[7:0] = value;
         OffBlockHigh: hdr_block[15:8] = value;
         OffLength: hdr_length = value;
         OffPad: ;
         OffSumLow: hdr_sum[7:0] = value;
         OffSumHigh: hdr_sum[15:8] = value;
         default: begin
            // Only bytes within the declared length count as payload.
            if ({16'd0, position} - HdrBytes < {24'd0, hdr_length}) begin
               r.payload_valid = 1'b1;
               r.payload_byte = value;
               payload_sum = payload_sum + {8'd0, value};
            end
         end
      endcase

      if (!last) begin
         if (position != PosMax) begin
            position = position + 16'd1;
         end
      end else begin
         // The final byte carries the verdict on the whole datagram.
         r.verdict_valid = 1'b1;
         span = {16'd0, position} + 32'd1;
         if (span < HdrBytes) begin
            r.verdict = VerdictShort;
         end else if (span - HdrBytes < {24'd0, hdr_length} || payload_sum != hdr_sum) begin
            r.verdict = VerdictError;
         end else if (hdr_length == 8'd0) begin
            r.verdict = VerdictComplete;
            r.ack_valid = 1'b1;
            r.ack_value = AckComplete;
         end else if (hdr_block == next_block) begin
            r.verdict = VerdictAccepted;
            r.ack_valid = 1'b1;
            r.ack_value = next_block;
            next_block = next_block + 16'd1;
            total_accepted = total_accepted + {24'd0, hdr_length};
         end else if (hdr_block < next_block) begin
            r.verdict = VerdictDuplicate;
            r.ack_valid = 1'b1;
            r.ack_value = hdr_block;
         end else begin
            r.verdict = VerdictAhead;
         end
         position = 16'd0;
         payload_sum = 16'd0;
      end
      r.bytes_accepted = total_accepted;
   endtask

   task automatic check_field(input string field, input logic [31:0] expected_value,
                              input logic [31:0] actual_value);
      if (actual_value !== expected_value) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, expected_value, actual_value);
         mismatches++;
      end
   endtask

   // Compare each result transfer first, then predict from each byte transfer.
   always @(posedge clock) begin
      if (reset) begin
         position = 16'd0;
         hdr_block = 16'd0;
         hdr_length = 8'd0;
         hdr_sum = 16'd0;
         payload_sum = 16'd0;
         next_block = 16'd0;
         total_accepted = 32'd0;
         results_due.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (results_due.size() == 0) begin
               $error("result transfer with no byte transfer waiting for it");
               mismatches++;
            end else begin
               want = results_due.pop_front();
               check_field("payload_byte", 32'(want.payload_byte), 32'(rsp_payload_byte));
               check_field("payload_valid", 32'(want.payload_valid),
                           32'(rsp_payload_valid));
               check_field("verdict_valid", 32'(want.verdict_valid),
                           32'(rsp_verdict_valid));
               check_field("verdict", 32'(want.verdict), 32'(rsp_verdict));
               check_field("ack_valid", 32'(want.ack_valid), 32'(rsp_ack_valid));
               check_field("ack_value", 32'(want.ack_value), 32'(rsp_ack_value));
               check_field("bytes_accepted", want.bytes_accepted, rsp_bytes_accepted);
            end
         end
         if (req_push && !req_full) begin
            classify_byte(req_rx_byte, req_end_of_datagram, want);
            results_due.push_back(want);
         end
      end
      pending <= results_due.size();
      failures <= mismatches;
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Testbench top for block_transfer_receiver_core: sends datagrams byte by
// byte, pops results at random and gives the verdict. Uses btr_checker.
module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_end_of_datagram = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_payload_valid;
   logic        rsp_verdict_valid;
   logic [2:0]  rsp_verdict;
   logic        rsp_ack_valid;
   logic [15:0] rsp_ack_value;
   logic [31:0] rsp_bytes_accepted;
   int unsigned pending;
   int unsigned failures;

   // Stimulus-side view of the block the receiver will accept next.
   logic [15:0] next_block = 16'd0;
   logic [7:0]  frame[$];
   int unsigned payload_sent = 0;
   bit          burst_mode = 1'b0;

   // Receiver-side idling state.
   int unsigned pop_wait = 0;
   int unsigned hold_left = 0;
   int unsigned pops_seen = 0;
   int unsigned rx_gap;
   bit          rx_eager = 1'b0;

   block_transfer_receiver_core dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_rx_byte(req_rx_byte),
      .req_end_of_datagram(req_end_of_datagram),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_payload_valid(rsp_payload_valid),
      .rsp_verdict_valid(rsp_verdict_valid),
      .rsp_verdict(rsp_verdict),
      .rsp_ack_valid(rsp_ack_valid),
      .rsp_ack_value(rsp_ack_value),
      .rsp_bytes_accepted(rsp_bytes_accepted)
   );

   btr_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_rx_byte(req_rx_byte),
      .req_end_of_datagram(req_end_of_datagram),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_payload_valid(rsp_payload_valid),
      .rsp_verdict_valid(rsp_verdict_valid),
      .rsp_verdict(rsp_verdict),
      .rsp_ack_valid(rsp_ack_valid),
      .rsp_ack_value(rsp_ack_value),
      .rsp_bytes_accepted(rsp_bytes_accepted),
      .pending(pending),
      .failures(failures)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // A wait of zero about a third of the time, otherwise a random wait.
   function automatic int unsigned draw_gap();
      if ($urandom_range(0, 2) == 0) begin
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   // Offers one byte after an idle gap and returns at the edge that takes it.
   task automatic send_byte(input logic [7:0] value, input logic last, input int unsigned gap);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_rx_byte <= value;
      req_end_of_datagram <= last;
      do @(posedge clock); while (req_full);
   endtask

   task automatic send_frame(input bit steady);
      int unsigned i;
      for (i = 0; i < frame.size(); i++) begin
         send_byte(frame[i], i == frame.size() - 1, (steady || burst_mode) ? 0 : draw_gap());
      end
      frame.delete();
   endtask

   // Builds and sends one datagram with a header. The checksum covers the
   // payload within the declared length unless it is to be spoiled.
   task automatic send_block(input logic [15:0] blk, input int unsigned len,
                             input int unsigned missing, input int unsigned surplus,
                             input bit sum_ok, input bit steady);
      logic [15:0] sum;
      logic [7:0]  len_byte;
      int unsigned i;
      sum = 16'd0;
      len_byte = len;
      frame.delete();
      for (i = 0; i < len - missing + surplus; i++) begin
         frame.push_back($urandom_range(0, 255));
         if (i < len) begin
            sum = sum + {8'd0, frame[i]};
         end
      end
      if (!sum_ok) begin
         sum = sum ^ $urandom_range(1, 65535);
      end
      frame.push_front(sum[15:8]);
      frame.push_front(sum[7:0]);
      frame.push_front($urandom_range(0, 255));
      frame.push_front(len_byte);
      frame.push_front(blk[15:8]);
      frame.push_front(blk[7:0]);
      payload_sent += frame.size();
      send_frame(steady);
      if (sum_ok && missing == 0 && len != 0 && blk == next_block) begin
         next_block = next_block + 16'd1;
      end
   endtask

   // Stops offering and waits until every expected result has come back.
   task automatic drain();
      req_push <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Result side: random pops, eager stretches and occasional long hold-offs.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (rsp_pop && !rsp_empty) begin
         pops_seen <= pops_seen + 1;
         if (pops_seen % 40 == 0) begin
            rx_eager <= ($urandom_range(0, 2) == 0);
         end
         if (!burst_mode && (pops_seen == 300 || $urandom_range(0, 255) == 0)) begin
            rsp_pop <= 1'b0;
            hold_left <= $urandom_range(64, 160);
         end else begin
            rx_gap = (burst_mode || rx_eager) ? 0 : draw_gap();
            rsp_pop <= (rx_gap == 0);
            pop_wait <= rx_gap;
         end
      end else if (pop_wait != 0) begin
         pop_wait <= pop_wait - 1;
         if (pop_wait == 1) begin
            rsp_pop <= 1'b1;
         end
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Stimulus and verdict.
   initial begin
      int unsigned pick;
      int unsigned len;
      int unsigned count;
      bit steady;
      bit paused;
      paused = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Short datagrams: a lone end marker and five bytes of all ones.
      frame.push_back(8'h00);
      send_frame(1'b0);
      repeat (5) frame.push_back(8'hFF);
      send_frame(1'b0);
      // Zero length with a zero checksum, then an accepted block and its repeat.
      send_block(16'hFFFF, 0, 0, 0, 1'b1, 1'b0);
      send_block(next_block, 1, 0, 0, 1'b1, 1'b0);
      send_block(16'd0, 1, 0, 0, 1'b1, 1'b0);
      drain();

      // Random datagrams, mostly well formed, starting with the longest payload.
      send_block(next_block, 255, 0, 0, 1'b1, 1'b0);
      while (payload_sent < 1050) begin
         steady = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 99);
         len = ($urandom_range(0, 31) == 0) ? $urandom_range(13, 255) : $urandom_range(1, 12);
         if (payload_sent >= 525 && !paused) begin
            drain();
            paused = 1'b1;
         end
         if (pick < 55) begin
            send_block(next_block, len, 0, 0, 1'b1, steady);
         end else if (pick < 63) begin
            send_block(next_block, len, 0, 0, 1'b0, steady);
         end else if (pick < 69) begin
            send_block(next_block, len, $urandom_range(1, len), 0, 1'b1, steady);
         end else if (pick < 76) begin
            send_block(next_block, len, 0, $urandom_range(1, 8), 1'b1, steady);
         end else if (pick < 81) begin
            send_block((next_block == 0) ? 16'd0 : $urandom_range(0, next_block - 1),
                       len, 0, 0, 1'b1, steady);
         end else if (pick < 86) begin
            send_block(next_block + $urandom_range(1, 65535 - next_block),
                       len, 0, 0, 1'b1, steady);
         end else if (pick < 90) begin
            send_block($urandom_range(0, 65535), 0, 0, $urandom_range(0, 3),
                       $urandom_range(0, 1), steady);
         end else begin
            // Short datagrams and plain noise of random length.
            count = (pick < 95) ? $urandom_range(1, 5) : $urandom_range(1, 20);
            repeat (count) frame.push_back($urandom_range(0, 255));
            send_frame(steady);
         end
      end
      drain();

      // A short run of blocks accepted back to back, then an ahead and a repeat.
      burst_mode <= 1'b1;
      repeat (8) send_block(next_block, 1, 0, 0, 1'b1, 1'b1);
      send_block(next_block, 3, 0, 0, 1'b1, 1'b0);
      send_block(16'hFFFF, 2, 0, 0, 1'b1, 1'b0);
      send_block(16'd0, 2, 0, 0, 1'b1, 1'b0);
      drain();
      burst_mode <= 1'b0;

      repeat (16) @(posedge clock);
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #4000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== block_transfer_receiver_core.f =====
sv/btr_pkg.sv
sv/btr_front.sv
sv/btr_queue.sv
sv/btr_back.sv
sv/block_transfer_receiver_core.sv
sim/btr_checker.sv
sim/testbench.sv
